// File: rtl/core/tap_pkg.sv
// Package for the tensor axis permute address core.
// Holds default sizes, register indexes and register reset values.
// Depends on nothing.
`default_nettype none
package tap_pkg;
  localparam int MAX_AXES_DEF    = 4;
  localparam int SIZE_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 32;
  localparam int ELEM_BITS       = 32;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int SIZE_REGS       = 4;
  localparam int BITS_PER_STAGE  = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_IN_SIZE_0  = 3'd1,
    REG_IN_SIZE_1  = 3'd2,
    REG_IN_SIZE_2  = 3'd3,
    REG_IN_SIZE_3  = 3'd4,
    REG_AXIS_ORDER = 3'd5
  } reg_idx_t;

  localparam logic [2:0]  AXIS_COUNT_RST = 3'd4;
  localparam logic [15:0] IN_SIZE_RST    = 16'd1;
  localparam logic [7:0]  AXIS_ORDER_RST = 8'd228;
endpackage
`default_nettype wire

// File: rtl/core/tensor_axis_permute_address.sv
// Top level of the tensor axis permute address core.
// Splits offsets into digits over pipelined long division, then recombines them.
// Depends on tap_pkg.
// Each axis digit takes ceil(OFFSET_BITS/4) division stages of four quotient
// bits, then one multiply-add stage per output axis.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output waits. Reset clears valid bits and loads register reset values.
`default_nettype none
module tensor_axis_permute_address_core #(
  parameter int MAX_AXES    = tap_pkg::MAX_AXES_DEF,
  parameter int SIZE_BITS   = tap_pkg::SIZE_BITS_DEF,
  parameter int OFFSET_BITS = tap_pkg::OFFSET_BITS_DEF,
  localparam int TDW = ((OFFSET_BITS + tap_pkg::ELEM_BITS + 7) / 8) * 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [TDW-1:0]                     in_tdata,   // in_offset, element_in
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [TDW-1:0]                          out_tdata,  // out_offset, element_out
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tap_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [tap_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int B  = tap_pkg::BITS_PER_STAGE;
  localparam int QS = (OFFSET_BITS + B - 1) / B;
  localparam int W  = QS * B;
  localparam int ND = MAX_AXES * QS;
  localparam int NS = ND + MAX_AXES;
  localparam int EB = tap_pkg::ELEM_BITS;

  typedef struct packed {
    logic [W-1:0]                         num;
    logic [SIZE_BITS-1:0]                 rem;
    logic [MAX_AXES-1:0][SIZE_BITS-1:0]   dig;
    logic [EB-1:0]                        elem;
  } stage_t;

  logic [2:0]  axis_count_r;
  logic [15:0] size_r [tap_pkg::SIZE_REGS];
  logic [7:0]  axis_order_r;

  logic [3:0]           ncnt;
  logic [SIZE_BITS-1:0] esz [MAX_AXES];

  stage_t           st_in  [NS];
  stage_t           st_nxt [NS];
  stage_t           st_r   [NS];
  logic [NS-1:0]    valid_r;
  logic             adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_count_r <= tap_pkg::AXIS_COUNT_RST;
      for (int i = 0; i < tap_pkg::SIZE_REGS; i++) size_r[i] <= tap_pkg::IN_SIZE_RST;
      axis_order_r <= tap_pkg::AXIS_ORDER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tap_pkg::REG_AXIS_COUNT: axis_count_r <= cfg_data[2:0];
        tap_pkg::REG_IN_SIZE_0:  size_r[0] <= cfg_data;
        tap_pkg::REG_IN_SIZE_1:  size_r[1] <= cfg_data;
        tap_pkg::REG_IN_SIZE_2:  size_r[2] <= cfg_data;
        tap_pkg::REG_IN_SIZE_3:  size_r[3] <= cfg_data;
        tap_pkg::REG_AXIS_ORDER: axis_order_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] sv;
    if (axis_count_r == 3'd0) ncnt = 4'd1;
    else if (int'(axis_count_r) > MAX_AXES) ncnt = 4'(MAX_AXES);
    else ncnt = {1'b0, axis_count_r};
    for (int p = 0; p < MAX_AXES; p++) begin
      sv = (p < tap_pkg::SIZE_REGS) ? size_r[p % tap_pkg::SIZE_REGS] : 16'd0;
      for (int b = 0; b < SIZE_BITS; b++) esz[p][b] = (b < 16) ? sv[b % 16] : 1'b0;
      if (p >= int'(ncnt) || esz[p] == '0) esz[p] = SIZE_BITS'(1);
    end
  end

  assign adv       = !valid_r[NS-1] || out_tready;
  assign in_tready = adv;

  always_comb begin
    st_in[0]      = '0;
    st_in[0].num  = W'(in_tdata[OFFSET_BITS-1:0]);
    st_in[0].elem = in_tdata[OFFSET_BITS +: EB];
    for (int s = 1; s < NS; s++) st_in[s] = st_r[s-1];
  end

  for (genvar s = 0; s < NS; s++) begin : g_st
    if (s < ND) begin : g_div
      localparam int P = MAX_AXES - 1 - s / QS;
      localparam int Q = s % QS;
      always_comb begin
        logic [SIZE_BITS:0]   rx;
        logic [W-1:0]         num;
        logic [SIZE_BITS-1:0] rem;
        st_nxt[s] = st_in[s];
        num = st_in[s].num;
        rem = (Q == 0) ? '0 : st_in[s].rem;
        for (int b = 0; b < B; b++) begin
          rx  = {rem, num[W-1]};
          num = {num[W-2:0], 1'b0};
          if (rx >= {1'b0, esz[P]}) begin
            rx     = rx - {1'b0, esz[P]};
            num[0] = 1'b1;
          end
          rem = rx[SIZE_BITS-1:0];
        end
        st_nxt[s].num = num;
        st_nxt[s].rem = rem;
        if (Q == QS - 1) st_nxt[s].dig[P] = rem;
      end
    end else begin : g_mul
      localparam int K = s - ND;
      always_comb begin
        logic [OFFSET_BITS-1:0]           acc;
        logic [OFFSET_BITS+SIZE_BITS-1:0] prod;
        logic [SIZE_BITS-1:0]             d;
        logic [SIZE_BITS-1:0]             m;
        logic [1:0]                       a;
        st_nxt[s] = st_in[s];
        acc  = (K == 0) ? '0 : st_in[s].num[OFFSET_BITS-1:0];
        a    = (K < 4) ? axis_order_r[2 * (K % 4) +: 2] : 2'd0;
        d    = '0;
        m    = SIZE_BITS'(1);
        for (int j = 0; j < MAX_AXES; j++) begin
          if (int'(a) == j && j < int'(ncnt)) begin
            d = st_in[s].dig[j];
            m = esz[j];
          end
        end
        prod = acc * m;
        if (K < int'(ncnt)) acc = prod[OFFSET_BITS-1:0] + OFFSET_BITS'(d);
        st_nxt[s].num = W'(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {valid_r[NS-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < NS; s++) st_r[s] <= st_nxt[s];
    end
  end

  assign out_tvalid = valid_r[NS-1];

  always_comb begin
    out_tdata                    = '0;
    out_tdata[OFFSET_BITS-1:0]   = st_r[NS-1].num[OFFSET_BITS-1:0];
    out_tdata[OFFSET_BITS +: EB] = st_r[NS-1].elem;
  end
endmodule
`default_nettype wire
